>>> rtl/core/stereo_feedback_delay_top_assert.svh
// Assertion macros shared by the delay core and its top level.
`ifndef STEREO_FEEDBACK_DELAY_TOP_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFD_AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFD_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sfd_pkg.sv
// Shared constants, types and arithmetic helpers of the stereo feedback delay.
`timescale 1ns / 1ps
`default_nettype none
package sfd_pkg;

	localparam int BUF_DEPTH = 131072;
	localparam int FADE_LEN  = 960;

	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int DLY_W  = ADDR_W + 8;
	localparam int FADE_W = $clog2(FADE_LEN + 1);
	localparam int SMP_W  = 24;
	localparam int CFG_W  = 25;
	localparam int IDX_W  = 3;
	localparam int T_W    = 17;
	localparam int WD_W   = 26;

	// Shared multiplier operand and product widths.
	localparam int MA_W = 33;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;
	localparam int WW   = MP_W + 2;

	localparam longint SPAN_L    = longint'(BUF_DEPTH) * 256;
	localparam longint DLY_MIN   = 256;
	localparam longint DLY_MAX_L = (longint'(BUF_DEPTH) - 4) * 256;
	localparam longint DLY_RST_IN = 6144000;
	localparam longint DLY_RST_L = (DLY_RST_IN < DLY_MIN) ? DLY_MIN :
		((DLY_RST_IN > DLY_MAX_L) ? DLY_MAX_L : DLY_RST_IN);

	localparam int T_STEP = 65536 / FADE_LEN;
	localparam int T_REM  = 65536 % FADE_LEN;

	localparam logic [31:0] S_A1 = 32'd1686629713;
	localparam logic [31:0] S_A3 = 32'd693598668;
	localparam logic [31:0] S_A5 = 32'd85569305;
	localparam logic [31:0] S_A7 = 32'd5026994;
	localparam logic [31:0] S_A9 = 32'd172272;

	localparam logic [15:0] Q15_ONE   = 16'd32768;
	localparam logic [14:0] FB_MAX    = 15'd31129;
	localparam logic [16:0] WIDTH_MAX = 17'd65536;

	typedef enum logic [IDX_W-1:0] {
		REG_DELAY = 3'd0,
		REG_MODE  = 3'd1,
		REG_FB    = 3'd2,
		REG_TONE  = 3'd3,
		REG_WIDTH = 3'd4,
		REG_DRY   = 3'd5,
		REG_WET   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DLY_W-1:0] old_delay;
		logic [DLY_W-1:0] active_delay;
		logic             fading;
		logic [T_W-1:0]   t;
		logic             mode;
		logic [14:0]      fbg;
		logic [15:0]      coeff;
		logic [16:0]      wg;
		logic [15:0]      dg;
		logic [15:0]      eg;
	} cfg_t;

	localparam logic signed [WW-1:0] S_HI = WW'(8388607);
	localparam logic signed [WW-1:0] S_LO = WW'(-8388608);

	function automatic logic signed [SMP_W-1:0] sat24(input logic signed [WW-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > S_HI) begin
			r = SMP_W'(S_HI);
		end else if (v < S_LO) begin
			r = SMP_W'(S_LO);
		end else begin
			r = SMP_W'(v);
		end
		return r;
	endfunction

	// Add half an LSB, then shift right with floor.
	function automatic logic signed [WW-1:0] rnd_shr(input logic signed [WW-1:0] v,
		input int unsigned n);
		logic signed [WW-1:0] half;
		half = WW'(1) <<< (n - 1);
		return (v + half) >>> n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/sfd_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module sfd_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/sfd_cfg.sv
// Configuration registers, delay change detection and crossfade progress.
`timescale 1ns / 1ps
`default_nettype none
module sfd_cfg import sfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic [CFG_W-1:0] data,
	input  wire logic             fade_adv,
	output cfg_t                  cfg
);

	localparam int CW = ((CFG_W > DLY_W) ? CFG_W : DLY_W) + 1;

	logic [DLY_W-1:0]  old_q, active_q;
	logic [FADE_W-1:0] fade_pos_q;
	logic [T_W-1:0]    t_q;
	logic [FADE_W:0]   rem_q;
	logic              mode_q;
	logic [14:0]       fbg_q;
	logic [15:0]       coeff_q, dg_q, eg_q;
	logic [16:0]       wg_q;

	logic [CW-1:0]    d_in, d_cl;
	logic [DLY_W-1:0] d_new;
	logic [DLY_W:0]   d_diff, d_abs;
	logic             d_big;
	logic [FADE_W:0]  rem_sum;
	logic             rem_carry;

	always_comb begin
		d_in = CW'(data);
		if (d_in < CW'(DLY_MIN)) begin
			d_cl = CW'(DLY_MIN);
		end else if (d_in > CW'(DLY_MAX_L)) begin
			d_cl = CW'(DLY_MAX_L);
		end else begin
			d_cl = d_in;
		end
		d_new  = DLY_W'(d_cl);
		d_diff = {1'b0, d_new} - {1'b0, active_q};
		d_abs  = d_diff[DLY_W] ? ((DLY_W + 1)'(0) - d_diff) : d_diff;
		d_big  = d_abs >= (DLY_W + 1)'(DLY_MIN);
		// Phase accumulator: t tracks floor(position * 65536 / FADE_LEN).
		rem_sum   = rem_q + (FADE_W + 1)'(T_REM);
		rem_carry = rem_sum >= (FADE_W + 1)'(FADE_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_q      <= DLY_W'(DLY_RST_L);
			active_q   <= DLY_W'(DLY_RST_L);
			fade_pos_q <= FADE_W'(FADE_LEN);
			t_q        <= '0;
			rem_q      <= '0;
			mode_q     <= 1'b0;
			fbg_q      <= '0;
			coeff_q    <= Q15_ONE;
			wg_q       <= 17'(Q15_ONE);
			dg_q       <= Q15_ONE;
			eg_q       <= '0;
		end else if (we) begin
			unique case (reg_idx_t'(index))
				REG_DELAY: begin
					if (d_big) begin
						old_q      <= active_q;
						active_q   <= d_new;
						fade_pos_q <= '0;
						t_q        <= '0;
						rem_q      <= '0;
					end
				end
				REG_MODE:  mode_q  <= data[0];
				REG_FB:    fbg_q   <= (data[14:0] > FB_MAX) ? FB_MAX : data[14:0];
				REG_TONE:  coeff_q <= (data[15:0] > Q15_ONE) ? Q15_ONE : data[15:0];
				REG_WIDTH: wg_q    <= (data[16:0] > WIDTH_MAX) ? WIDTH_MAX : data[16:0];
				REG_DRY:   dg_q    <= (data[15:0] > Q15_ONE) ? Q15_ONE : data[15:0];
				REG_WET:   eg_q    <= (data[15:0] > Q15_ONE) ? Q15_ONE : data[15:0];
				default: ;
			endcase
		end else if (fade_adv && cfg.fading) begin
			fade_pos_q <= fade_pos_q + 1'b1;
			t_q        <= t_q + T_W'(T_STEP) + T_W'(rem_carry);
			rem_q      <= rem_carry ? (rem_sum - (FADE_W + 1)'(FADE_LEN)) : rem_sum;
		end
	end

	always_comb begin
		cfg.old_delay    = old_q;
		cfg.active_delay = active_q;
		cfg.fading       = fade_pos_q < FADE_W'(FADE_LEN);
		cfg.t            = t_q;
		cfg.mode         = mode_q;
		cfg.fbg          = fbg_q;
		cfg.coeff        = coeff_q;
		cfg.wg           = wg_q;
		cfg.dg           = dg_q;
		cfg.eg           = eg_q;
	end

endmodule
`default_nettype wire

>>> rtl/core/sfd_core.sv
// Delay memories and the step sequencer around one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_feedback_delay_top_assert.svh"
module sfd_core import sfd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [SMP_W-1:0] in_left,
	input  wire logic signed [SMP_W-1:0] in_right,
	input  wire cfg_t                    cfg,
	output logic                         fade_adv,
	input  wire logic                    out_free,
	output logic                         done,
	output logic signed [SMP_W-1:0]      out_left,
	output logic signed [SMP_W-1:0]      out_right
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef enum logic [5:0] {
		K_SQ_A, K_SQ_B, K_T2B, K_A7A, K_A7B, K_A5A, K_A5B, K_A3A, K_A3B,
		K_A1A, K_A1B, K_GA, K_GB, K_LO1, K_LN0, K_LN1, K_RO0, K_RO1,
		K_RN0, K_RN1, K_XLO, K_XLN, K_XRO, K_XRN, K_TNL, K_TNR, K_FBL,
		K_FBR, K_DIF, K_WR, K_OL0, K_OR0, K_OR1, K_END
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [ADDR_W-1:0] wi_q;
	logic              wrap_q;
	logic signed [SMP_W-1:0] tone_l_q, tone_r_q;

	logic signed [SMP_W-1:0] dl_q, dr_q;
	logic [DLY_W-1:0] po_q, pn_q;
	logic             fade_q;
	logic [T_W-1:0]   ta_q;

	logic signed [SMP_W-1:0] lo0_q, lo1_q, ln0_q, ln1_q, ro0_q, ro1_q, rn0_q, rn1_q;
	logic signed [SMP_W-1:0] tlo_q, tln_q, tro_q, trn_q, rl_q, rr_q, fbl_q, fbr_q;
	logic signed [WD_W-1:0]  wl_q, wr_q;
	logic signed [SMP_W-1:0] out_l_q, out_r_q;
	logic [31:0]      pa_q, pb_q;
	logic [T_W-1:0]   t2a_q, t2b_q;
	logic [15:0]      ga_q, gb_q;
	logic signed [MP_W-1:0] acc_q, mul_q;
	logic             rv_s1;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [T_W-1:0]    tb;
	logic [ADDR_W-1:0] raddr;
	logic              rvalid;
	logic [SMP_W-1:0]  rd_l, rd_r;
	logic              ram_we;
	logic [SMP_W-1:0]  wd_l, wd_r;
	logic signed [WW-1:0] acc_sum, sum_w, mono_w;
	logic [8:0]        wo0, wn0;

	function automatic logic [DLY_W-1:0] tap_pos(input logic [ADDR_W-1:0] wi,
		input logic [DLY_W-1:0] d);
		logic [DLY_W:0] diff;
		diff = {1'b0, wi, 8'b0} - {1'b0, d};
		if (diff[DLY_W]) begin
			diff = diff + (DLY_W + 1)'(SPAN_L);
		end
		return diff[DLY_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] nxt(input logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(BUF_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [15:0] gain_fin(input logic signed [MP_W-1:0] m);
		logic [32:0] gsum;
		logic [17:0] g;
		gsum = 33'(m[47:16]) + 33'd16384;
		g    = gsum[32:15];
		return (g > 18'(Q15_ONE)) ? Q15_ONE : g[15:0];
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign fade_adv = in_valid && in_ready;
	assign done     = (state_q == ST_DONE) && out_free;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign ram_we   = (state_q == ST_RUN) && (step_q == K_WR);

	assign tb  = T_W'(65536) - ta_q;
	assign wo0 = 9'd256 - {1'b0, po_q[7:0]};
	assign wn0 = 9'd256 - {1'b0, pn_q[7:0]};
	assign acc_sum = WW'(acc_q) + WW'(mul_q);

	// Read address order: old tap pair, then new tap pair.
	always_comb begin
		case (step_q)
			K_SQ_A:  raddr = po_q[DLY_W-1:8];
			K_SQ_B:  raddr = nxt(po_q[DLY_W-1:8]);
			K_T2B:   raddr = pn_q[DLY_W-1:8];
			default: raddr = nxt(pn_q[DLY_W-1:8]);
		endcase
		// Entries not yet written since reset read as zero.
		rvalid = wrap_q || (raddr < wi_q);
	end

	always_comb begin
		mono_w = (WW'(dl_q) + WW'(dr_q)) >>> 1;
		sum_w  = (WW'(rl_q) + WW'(rr_q)) <<< 15;
		if (cfg.mode) begin
			wd_l = sat24(mono_w + WW'(fbr_q));
			wd_r = fbl_q;
		end else begin
			wd_l = sat24(mono_w + WW'(fbl_q));
			wd_r = sat24(mono_w + WW'(fbr_q));
		end
	end

	always_comb begin
		case (step_q)
			K_SQ_A: begin mul_a = MA_W'(ta_q); mul_b = MB_W'(ta_q); end
			K_SQ_B: begin mul_a = MA_W'(tb);   mul_b = MB_W'(tb);   end
			K_T2B, K_A7B, K_A5B, K_A3B: begin
				mul_a = MA_W'(pa_q); mul_b = MB_W'(t2a_q);
			end
			K_A7A, K_A5A, K_A3A, K_A1A: begin
				mul_a = MA_W'(pb_q); mul_b = MB_W'(t2b_q);
			end
			K_A1B:  begin mul_a = MA_W'(pa_q);  mul_b = MB_W'(ta_q); end
			K_GA:   begin mul_a = MA_W'(pb_q);  mul_b = MB_W'(tb);   end
			K_GB:   begin mul_a = MA_W'(lo0_q); mul_b = MB_W'(wo0);  end
			K_LO1:  begin mul_a = MA_W'(lo1_q); mul_b = MB_W'(po_q[7:0]); end
			K_LN0:  begin mul_a = MA_W'(ln0_q); mul_b = MB_W'(wn0);  end
			K_LN1:  begin mul_a = MA_W'(ln1_q); mul_b = MB_W'(pn_q[7:0]); end
			K_RO0:  begin mul_a = MA_W'(ro0_q); mul_b = MB_W'(wo0);  end
			K_RO1:  begin mul_a = MA_W'(ro1_q); mul_b = MB_W'(po_q[7:0]); end
			K_RN0:  begin mul_a = MA_W'(rn0_q); mul_b = MB_W'(wn0);  end
			K_RN1:  begin mul_a = MA_W'(rn1_q); mul_b = MB_W'(pn_q[7:0]); end
			K_XLO:  begin mul_a = MA_W'(tlo_q); mul_b = MB_W'(gb_q); end
			K_XLN:  begin mul_a = MA_W'(tln_q); mul_b = MB_W'(ga_q); end
			K_XRO:  begin mul_a = MA_W'(tro_q); mul_b = MB_W'(gb_q); end
			K_XRN:  begin mul_a = MA_W'(trn_q); mul_b = MB_W'(ga_q); end
			K_TNL:  begin mul_a = MA_W'(rl_q) - MA_W'(tone_l_q); mul_b = MB_W'(cfg.coeff); end
			K_TNR:  begin mul_a = MA_W'(rr_q) - MA_W'(tone_r_q); mul_b = MB_W'(cfg.coeff); end
			K_FBL:  begin mul_a = MA_W'(tone_l_q); mul_b = MB_W'(cfg.fbg); end
			K_FBR:  begin mul_a = MA_W'(tone_r_q); mul_b = MB_W'(cfg.fbg); end
			K_DIF:  begin mul_a = MA_W'(rl_q) - MA_W'(rr_q); mul_b = MB_W'(cfg.wg); end
			K_WR:   begin mul_a = MA_W'(dl_q);  mul_b = MB_W'(cfg.dg); end
			K_OL0:  begin mul_a = MA_W'(wl_q);  mul_b = MB_W'(cfg.eg); end
			K_OR0:  begin mul_a = MA_W'(dr_q);  mul_b = MB_W'(cfg.dg); end
			K_OR1:  begin mul_a = MA_W'(wr_q);  mul_b = MB_W'(cfg.eg); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	sfd_ram #(.DEPTH(BUF_DEPTH), .WIDTH(SMP_W)) u_ram_l (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wi_q),
		.wdata (wd_l),
		.raddr (raddr),
		.rdata (rd_l)
	);

	sfd_ram #(.DEPTH(BUF_DEPTH), .WIDTH(SMP_W)) u_ram_r (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wi_q),
		.wdata (wd_r),
		.raddr (raddr),
		.rdata (rd_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= K_SQ_A;
			wi_q     <= '0;
			wrap_q   <= 1'b0;
			tone_l_q <= '0;
			tone_r_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= K_SQ_A;
					end
				end
				ST_RUN: begin
					if (step_q == K_END) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_t'(step_q + 6'd1);
					end
					if (step_q == K_TNR) begin
						tone_l_q <= sat24(WW'(tone_l_q) + rnd_shr(WW'(mul_q), 15));
					end
					if (step_q == K_FBL) begin
						tone_r_q <= sat24(WW'(tone_r_q) + rnd_shr(WW'(mul_q), 15));
					end
					if (ram_we) begin
						wi_q <= nxt(wi_q);
						if (wi_q == ADDR_W'(BUF_DEPTH - 1)) begin
							wrap_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		rv_s1 <= rvalid;
		if (fade_adv) begin
			dl_q   <= in_left;
			dr_q   <= in_right;
			po_q   <= tap_pos(wi_q, cfg.old_delay);
			pn_q   <= tap_pos(wi_q, cfg.active_delay);
			fade_q <= cfg.fading;
			ta_q   <= cfg.t;
		end
		// Step captures only while the sequence runs; the step register parks on
		// its last value while a result waits.
		if (state_q == ST_RUN) begin
			case (step_q)
				K_SQ_B: begin
					lo0_q <= rv_s1 ? signed'(rd_l) : '0;
					ro0_q <= rv_s1 ? signed'(rd_r) : '0;
					t2a_q <= mul_q[32:16];
					pa_q  <= S_A9;
					pb_q  <= S_A9;
				end
				K_T2B: begin
					lo1_q <= rv_s1 ? signed'(rd_l) : '0;
					ro1_q <= rv_s1 ? signed'(rd_r) : '0;
					t2b_q <= mul_q[32:16];
				end
				K_A7A: begin
					ln0_q <= rv_s1 ? signed'(rd_l) : '0;
					rn0_q <= rv_s1 ? signed'(rd_r) : '0;
					pa_q  <= S_A7 - mul_q[47:16];
				end
				K_A7B: begin
					ln1_q <= rv_s1 ? signed'(rd_l) : '0;
					rn1_q <= rv_s1 ? signed'(rd_r) : '0;
					pb_q  <= S_A7 - mul_q[47:16];
				end
				K_A5A: pa_q <= S_A5 - mul_q[47:16];
				K_A5B: pb_q <= S_A5 - mul_q[47:16];
				K_A3A: pa_q <= S_A3 - mul_q[47:16];
				K_A3B: pb_q <= S_A3 - mul_q[47:16];
				K_A1A: pa_q <= S_A1 - mul_q[47:16];
				K_A1B: pb_q <= S_A1 - mul_q[47:16];
				K_GA:  ga_q <= gain_fin(mul_q);
				K_GB:  gb_q <= gain_fin(mul_q);
				K_LO1, K_LN1, K_RO1, K_RN1, K_XLN, K_XRN, K_OL0, K_OR1: acc_q <= mul_q;
				K_LN0: tlo_q <= SMP_W'(rnd_shr(acc_sum, 8));
				K_RO0: tln_q <= SMP_W'(rnd_shr(acc_sum, 8));
				K_RN0: tro_q <= SMP_W'(rnd_shr(acc_sum, 8));
				K_XLO: trn_q <= SMP_W'(rnd_shr(acc_sum, 8));
				K_XRO: rl_q  <= fade_q ? sat24(rnd_shr(acc_sum, 15)) : tln_q;
				K_TNL: rr_q  <= fade_q ? sat24(rnd_shr(acc_sum, 15)) : trn_q;
				K_FBR: fbl_q <= SMP_W'(rnd_shr(WW'(mul_q), 15));
				K_DIF: fbr_q <= SMP_W'(rnd_shr(WW'(mul_q), 15));
				K_WR: begin
					wl_q <= WD_W'(rnd_shr(sum_w + WW'(mul_q), 16));
					wr_q <= WD_W'(rnd_shr(sum_w - WW'(mul_q), 16));
				end
				K_OR0: out_l_q <= sat24(rnd_shr(acc_sum, 15));
				K_END: out_r_q <= sat24(rnd_shr(acc_sum, 15));
				default: ;
			endcase
		end
	end

	`SFD_AST_NEXT(a_accept_runs, (state_q == ST_IDLE) && in_valid, state_q == ST_RUN,
		"accepted sample did not start the sequence")
	`SFD_AST_NEXT(a_write_moves_index, ram_we, wi_q != $past(wi_q),
		"write index did not advance after a buffer write")
	`SFD_AST_IMPL(a_gains_bounded, state_q == ST_DONE,
		(ga_q <= Q15_ONE) && (gb_q <= Q15_ONE), "crossfade gain above unity")

endmodule
`default_nettype wire

>>> rtl/core/stereo_feedback_delay_top.sv
// Top level of the stereo feedback delay: stream ports, config port, output register.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[23:0] left_in, tdata[47:24] right_in
//  m_axis    out        tdata[23:0] left_out, tdata[47:24] right_out
//  cfg       in         cfg_we, cfg_index (register number), cfg_data[24:0]
//
// Each input beat passes through an accept state, 34 sequencer steps and a state
// that hands the result to the output register. The sequence is set by the single
// 33x18 multiplier, which computes all of a sample's products one after another.
// The next input beat is taken while the previous result still waits on m_axis.
// Reset is asynchronous (arst_n low); the delay memories are not swept, a fill
// pointer and a wrap flag make every entry not yet written read as zero.
// A stalled m_axis holds its beat and, once a second result is ready, the input.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_feedback_delay_top_assert.svh"
module stereo_feedback_delay_top import sfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [47:0]      s_tdata,   // [23:0] left_in, [47:24] right_in
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [47:0]           m_tdata,   // [23:0] left_out, [47:24] right_out
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cfg_t cfg;
	logic fade_adv;
	logic done;
	logic out_free;
	logic signed [SMP_W-1:0] res_l, res_r;
	logic        m_valid_q;
	logic [47:0] m_data_q;

	// Configuration registers also track the crossfade; they advance it once per
	// accepted beat while a fade is running and no config write is taken.
	sfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (cfg_we),
		.index    (cfg_index),
		.data     (cfg_data),
		.fade_adv (fade_adv),
		.cfg      (cfg)
	);

	// The output register is free when empty or being drained in this cycle.
	assign out_free = !m_valid_q || m_tready;

	sfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_left   (s_tdata[23:0]),
		.in_right  (s_tdata[47:24]),
		.cfg       (cfg),
		.fade_adv  (fade_adv),
		.out_free  (out_free),
		.done      (done),
		.out_left  (res_l),
		.out_right (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_data_q <= {res_r, res_l};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`SFD_AST_IMPL(a_no_overwrite, done, !m_valid_q || m_tready,
		"result loaded over a beat not yet taken")

endmodule
`default_nettype wire
